// ===== design/bdq_pkg.sv =====
// Package for the bounded deque with indexed read.
// Holds sizes, operation and status codes, and the RAM access struct.
// No dependencies.
package bdq_pkg;

  localparam int unsigned DEPTH   = 256;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W   = 9;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned STAT_W  = 2;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(256);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  typedef enum logic [KIND_W-1:0] {
    KIND_READ         = 3'd0,
    KIND_INSERT_FRONT = 3'd1,
    KIND_INSERT_BACK  = 3'd2,
    KIND_REMOVE_FRONT = 3'd3,
    KIND_REMOVE_BACK  = 3'd4
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK           = 2'd0,
    ST_OUT_OF_RANGE = 2'd1,
    ST_FULL         = 2'd2,
    ST_EMPTY        = 2'd3
  } status_e;

  typedef struct packed {
    logic                     en;
    logic                     we;
    logic [ADDR_W-1:0]        addr;
    logic signed [WORD_W-1:0] wdata;
  } ram_req_t;

endpackage

// ===== design/bdq_if.sv =====
// Request and response channel interfaces for the deque.
// Depends on bdq_pkg for field widths.
interface bdq_req_if;
  logic                              valid;
  logic                              ready;
  logic [bdq_pkg::KIND_W-1:0]        kind;
  logic [bdq_pkg::POS_W-1:0]         position;
  logic signed [bdq_pkg::WORD_W-1:0] word_in;

  modport source (output valid, kind, position, word_in, input ready);
  modport sink   (input valid, kind, position, word_in, output ready);
endinterface

interface bdq_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [bdq_pkg::WORD_W-1:0] word_out;
  logic [bdq_pkg::STAT_W-1:0]        status;
  logic [bdq_pkg::CNT_W-1:0]         entry_count;

  modport source (output valid, word_out, status, entry_count, input ready);
  modport sink   (input valid, word_out, status, entry_count, output ready);
endinterface

// ===== design/bdq_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
// Read data holds until the next enabled read. No dependencies.
module bdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/bdq_ctrl.sv =====
// Deque controller: head pointer, count, capacity register and response register.
// Drives the ring-buffer RAM; depends on bdq_pkg and bdq_if.
module bdq_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  bdq_req_if.sink                           req_i,
  bdq_rsp_if.source                         rsp_o,
  input  logic                              cfg_we_i,
  input  logic [bdq_pkg::CNT_W-1:0]         cfg_wdata_i,
  output bdq_pkg::ram_req_t                 ram_req_o,
  input  logic signed [bdq_pkg::WORD_W-1:0] ram_rdata_i
);
  import bdq_pkg::*;

  logic [ADDR_W-1:0] head_q, head_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  cap_q;
  logic [CNT_W-1:0]  eff_cap;
  logic              rsp_valid_q;
  logic              rd_ok_q, rd_ok_d;
  status_e           status_q, status_d;
  logic              accept;
  logic              full;
  logic              empty;
  ram_req_t          ram_req;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign eff_cap     = (cap_q > DEPTH_CNT) ? DEPTH_CNT : cap_q;
  assign full        = cnt_q >= eff_cap;
  assign empty       = cnt_q == '0;

  always_comb begin
    head_d        = head_q;
    cnt_d         = cnt_q;
    status_d      = ST_OK;
    rd_ok_d       = 1'b0;
    ram_req.en    = 1'b0;
    ram_req.we    = 1'b0;
    ram_req.addr  = head_q;
    ram_req.wdata = req_i.word_in;
    unique case (req_i.kind)
      KIND_READ: begin
        if (CNT_W'(req_i.position) < cnt_q) begin
          rd_ok_d      = 1'b1;
          ram_req.en   = 1'b1;
          ram_req.addr = head_q + ADDR_W'(req_i.position);
        end else begin
          status_d = ST_OUT_OF_RANGE;
        end
      end
      KIND_INSERT_FRONT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          head_d       = head_q - ADDR_W'(1);
          cnt_d        = cnt_q + CNT_W'(1);
          ram_req.en   = 1'b1;
          ram_req.we   = 1'b1;
          ram_req.addr = head_q - ADDR_W'(1);
        end
      end
      KIND_INSERT_BACK: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          cnt_d        = cnt_q + CNT_W'(1);
          ram_req.en   = 1'b1;
          ram_req.we   = 1'b1;
          ram_req.addr = head_q + cnt_q[ADDR_W-1:0];
        end
      end
      KIND_REMOVE_FRONT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          head_d = head_q + ADDR_W'(1);
          cnt_d  = cnt_q - CNT_W'(1);
        end
      end
      KIND_REMOVE_BACK: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
    ram_req.en = ram_req.en && accept;
  end

  assign ram_req_o = ram_req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      cnt_q       <= '0;
      cap_q       <= CAP_RESET;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (accept) begin
        head_q      <= head_d;
        cnt_q       <= cnt_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_ok_q  <= rd_ok_d;
      status_q <= status_d;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.word_out    = rd_ok_q ? ram_rdata_i : '0;
  assign rsp_o.status      = status_q;
  assign rsp_o.entry_count = cnt_q;

endmodule

// ===== design/bounded_deque_with_index_read_unit.sv =====
// Bounded double-ended queue of signed 32-bit words with indexed read.
// Top level: controller plus one ring-buffer RAM; depends on bdq_pkg, bdq_if,
// bdq_ram and bdq_ctrl.
// Use:
//   req_i carries one operation per transaction: kind (read at index, insert
//   front, insert back, remove front, remove back), position and word_in.
//   rsp_o returns exactly one transaction per request: word_out, status and
//   the entry count after the operation.
//   cfg_we_i/cfg_wdata_i write the capacity register; values above 256
//   act as 256. Write it only while no request is in flight.
// Timing:
//   The response is registered and is valid in the cycle after the request
//   transaction. One request per cycle is taken while the response side
//   keeps up; the figure is set by the single RAM port, serving each access
//   in its accept cycle, with read data registered for the reply.
// Reset:
//   The list is empty, head is zero, capacity is 256. RAM contents are left
//   undefined and need no clearing pass, since only written entries are read.
// Stall:
//   While a response waits on rsp_o.ready, it is held and req_i.ready is low.
module bounded_deque_with_index_read_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  bdq_req_if.sink                   req_i,
  bdq_rsp_if.source                 rsp_o,
  input  logic                      cfg_we_i,
  input  logic [bdq_pkg::CNT_W-1:0] cfg_wdata_i
);
  import bdq_pkg::*;

  ram_req_t                 ram_req;
  logic signed [WORD_W-1:0] ram_rdata;

  bdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  bdq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_req.en),
    .we_i    (ram_req.we),
    .addr_i  (ram_req.addr),
    .wdata_i (ram_req.wdata),
    .rdata_o (ram_rdata)
  );

endmodule

// ===== tb/bounded_deque_with_index_read_unit_test.sv =====
// Testbench for the bounded deque with indexed read: random and directed
// operations against an in-bench prediction of the ring-buffer list.
// Depends on bdq_pkg, bdq_if and the bounded_deque_with_index_read_unit RTL.
module bounded_deque_with_index_read_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bdq_pkg::*;

  localparam logic [KIND_W-1:0] KIND_FIRST_UNUSED = 3'd5;
  localparam logic [KIND_W-1:0] KIND_LAST_UNUSED  = 3'd7;
  localparam int LONG_HOLD   = 300;
  localparam int TAIL_CYCLES = 4;

  typedef enum int {RX_STEADY, RX_HALF, RX_SPARSE} rx_mode_e;

  typedef struct {
    logic signed [WORD_W-1:0] word_out;
    logic [STAT_W-1:0]        status;
    logic [CNT_W-1:0]         entry_count;
  } deque_reply_t;

  class deque_scoreboard;
    logic signed [WORD_W-1:0] words [DEPTH];
    logic [ADDR_W-1:0]        head;
    logic [CNT_W-1:0]         count;
    logic [CNT_W-1:0]         capacity;
    deque_reply_t             replies_due [$];
    int                       mismatches;

    function new();
      head       = '0;
      count      = '0;
      capacity   = CAP_RESET;
      mismatches = 0;
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    function void set_capacity(logic [CNT_W-1:0] value);
      capacity = value;
    endfunction

    function void report_mismatch(string what);
      mismatches++;
      $display("%0t: error: %s", $time, what);
    endfunction

    function void note_request(logic [KIND_W-1:0] kind, logic [POS_W-1:0] position,
                               logic signed [WORD_W-1:0] word_in);
      deque_reply_t      r;
      logic [CNT_W-1:0]  limit;
      r.word_out = '0;
      r.status   = ST_OK;
      limit = (capacity > DEPTH_CNT) ? DEPTH_CNT : capacity;
      case (kind)
        KIND_READ: begin
          if (CNT_W'(position) < count) begin
            r.word_out = words[head + ADDR_W'(position)];
          end else begin
            r.status = ST_OUT_OF_RANGE;
          end
        end
        KIND_INSERT_FRONT: begin
          if (count >= limit) begin
            r.status = ST_FULL;
          end else begin
            head        = head - 1'b1;
            words[head] = word_in;
            count       = count + 1'b1;
          end
        end
        KIND_INSERT_BACK: begin
          if (count >= limit) begin
            r.status = ST_FULL;
          end else begin
            words[head + ADDR_W'(count)] = word_in;
            count = count + 1'b1;
          end
        end
        KIND_REMOVE_FRONT: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            head  = head + 1'b1;
            count = count - 1'b1;
          end
        end
        KIND_REMOVE_BACK: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            count = count - 1'b1;
          end
        end
        default: ;
      endcase
      r.entry_count = count;
      replies_due.push_back(r);
    endfunction

    function void check_reply(logic signed [WORD_W-1:0] word_out, logic [STAT_W-1:0] status,
                              logic [CNT_W-1:0] entry_count);
      deque_reply_t r;
      if (replies_due.size() == 0) begin
        report_mismatch("reply with no request outstanding");
        return;
      end
      r = replies_due.pop_front();
      if (word_out !== r.word_out) begin
        report_mismatch($sformatf("word_out %h, predicted %h", word_out, r.word_out));
      end
      if (status !== r.status) begin
        report_mismatch($sformatf("status %0d, predicted %0d", status, r.status));
      end
      if (entry_count !== r.entry_count) begin
        report_mismatch($sformatf("entry_count %0d, predicted %0d",
                                  entry_count, r.entry_count));
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CNT_W-1:0] cfg_wdata_i;
  bit               hold_wanted;

  deque_scoreboard board = new();

  bdq_req_if req_if();
  bdq_rsp_if rsp_if();

  bounded_deque_with_index_read_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        board.note_request(req_if.kind, req_if.position, req_if.word_in);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        board.check_reply(rsp_if.word_out, rsp_if.status, rsp_if.entry_count);
      end
    end
  end

  initial begin
    rx_mode_e mode;
    int       len;
    rsp_if.ready = 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_wanted) begin
        hold_wanted = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      mode = rx_mode_e'($urandom_range(0, 2));
      len  = $urandom_range(20, 120);
      for (int n = 0; n < len && !hold_wanted; n++) begin
        case (mode)
          RX_STEADY: rsp_if.ready <= 1'b1;
          RX_HALF:   rsp_if.ready <= 1'($urandom_range(0, 1));
          default:   rsp_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  function automatic logic signed [WORD_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Hold the transaction until the block takes it.
  task automatic drive_req(logic [KIND_W-1:0] kind, logic [POS_W-1:0] position,
                           logic signed [WORD_W-1:0] word_in);
    req_if.valid    <= 1'b1;
    req_if.kind     <= kind;
    req_if.position <= position;
    req_if.word_in  <= word_in;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (board.pending() != 0);
  endtask

  task automatic write_capacity(logic [CNT_W-1:0] value);
    wait_drained();
    repeat (2) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_capacity(value);
  endtask

  task automatic run_phase(int items, int insert_pct);
    int                burst;
    int                gap;
    int                pick;
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  position;
    burst = $urandom_range(1, 16);
    for (int i = 0; i < items; i++) begin
      pick     = $urandom_range(0, 99);
      position = POS_W'($urandom);
      if (pick < 25) begin
        kind = KIND_READ;
        if (board.count != 0 && $urandom_range(0, 3) != 0) begin
          position = POS_W'($urandom_range(0, int'(board.count) - 1));
        end
      end else if (pick < 28) begin
        kind = KIND_W'($urandom_range(KIND_FIRST_UNUSED, KIND_LAST_UNUSED));
      end else if ($urandom_range(0, 99) < insert_pct) begin
        kind = $urandom_range(0, 1) ? KIND_INSERT_FRONT : KIND_INSERT_BACK;
      end else begin
        kind = $urandom_range(0, 1) ? KIND_REMOVE_FRONT : KIND_REMOVE_BACK;
      end
      drive_req(kind, position, random_word());
      burst--;
      if (i == items - 1) begin
        req_if.valid <= 1'b0;
      end else if (burst == 0) begin
        burst = $urandom_range(1, 16);
        gap   = $urandom_range(0, 4);
        if (gap != 0) begin
          req_if.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    hold_wanted     = 1'b0;
    req_if.valid    = 1'b0;
    req_if.kind     = KIND_READ;
    req_if.position = '0;
    req_if.word_in  = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    drive_req(KIND_READ, 8'd0, 32'd0);
    drive_req(KIND_REMOVE_FRONT, 8'd0, 32'd0);
    drive_req(KIND_REMOVE_BACK, 8'd0, 32'd0);
    drive_req(KIND_FIRST_UNUSED, 8'hff, 32'hffff_ffff);
    drive_req(KIND_FIRST_UNUSED + 1'b1, 8'd0, 32'd0);
    drive_req(KIND_LAST_UNUSED, 8'd0, 32'd0);
    drive_req(KIND_INSERT_BACK, 8'd0, 32'h7fff_ffff);
    drive_req(KIND_INSERT_FRONT, 8'd0, 32'h8000_0000);
    drive_req(KIND_INSERT_BACK, 8'd0, 32'hffff_ffff);
    drive_req(KIND_INSERT_FRONT, 8'd0, 32'd0);
    drive_req(KIND_INSERT_BACK, 8'h55, 32'h5555_5555);
    drive_req(KIND_INSERT_FRONT, 8'haa, 32'haaaa_aaaa);
    drive_req(KIND_READ, 8'd0, 32'd0);
    drive_req(KIND_READ, 8'd1, 32'd0);
    drive_req(KIND_READ, 8'd5, 32'd0);
    drive_req(KIND_READ, 8'd6, 32'd0);
    drive_req(KIND_READ, 8'hff, 32'd0);
    drive_req(KIND_LAST_UNUSED, 8'd2, 32'h1234_5678);
    drive_req(KIND_REMOVE_FRONT, 8'd0, 32'd0);
    drive_req(KIND_REMOVE_BACK, 8'd0, 32'd0);
    drive_req(KIND_READ, 8'd0, 32'd0);
    drive_req(KIND_READ, 8'd3, 32'd0);
    drive_req(KIND_READ, 8'd4, 32'd0);
    req_if.valid <= 1'b0;

    write_capacity(CAP_RESET);
    hold_wanted = 1'b1;
    run_phase(400, 97);
    write_capacity(9'd5);
    run_phase(100, 50);
    write_capacity(9'd0);
    run_phase(40, 50);
    write_capacity(9'd511);
    run_phase(300, 5);
    write_capacity(9'd1);
    run_phase(60, 60);
    write_capacity(9'd2);
    run_phase(60, 60);
    write_capacity(9'd300);
    run_phase(80, 50);
    write_capacity(9'd17);
    run_phase(100, 55);
    write_capacity(CAP_RESET);
    hold_wanted = 1'b1;
    run_phase(100, 50);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule
